// ----- design/lsps_pkg.sv -----
// ----------------------------------------------------------------------------
// lsps_pkg
// shared types and constants for the led strip pattern sequencer
// ----------------------------------------------------------------------------
package lsps_pkg;

  localparam int RGB_W  = 24;
  localparam int MODE_W = 3;
  localparam int PIX_W  = 6;

  typedef logic [RGB_W-1:0]  rgb_t;
  typedef logic [MODE_W-1:0] mode_t;
  typedef logic [PIX_W-1:0]  pix_idx_t;

  localparam mode_t MODE_BLANK   = 3'd0;
  localparam mode_t MODE_SOLID   = 3'd1;
  localparam mode_t MODE_RUN_FWD = 3'd2;
  localparam mode_t MODE_RUN_REV = 3'd3;
  localparam mode_t MODE_BOUNCE  = 3'd4;
  localparam mode_t MODE_NONE    = 3'd7;

  localparam rgb_t RGB_BLACK = 24'h000000;

  // register select, taken from address bit 2
  localparam logic REG_MODE  = 1'b0;
  localparam logic REG_COLOR = 1'b1;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_UP,
    CELL_DOWN
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
  } cell_ctl_t;

endpackage

// ----- design/lsps_if.sv -----
// ----------------------------------------------------------------------------
// lsps_if
// valid/ready channels for tick input and pixel output beats
// ----------------------------------------------------------------------------
interface lsps_in_if;
  logic valid;
  logic ready;
  logic advance;

  modport source (output valid, output advance, input ready);
  modport sink (input valid, input advance, output ready);
endinterface

interface lsps_out_if;
  logic              valid;
  logic              ready;
  lsps_pkg::pix_idx_t pixel_index;
  lsps_pkg::rgb_t     pixel_rgb;
  logic              last_pixel;

  modport source (output valid, output pixel_index, output pixel_rgb,
                  output last_pixel, input ready);
  modport sink (input valid, input pixel_index, input pixel_rgb,
                input last_pixel, output ready);
endinterface

// ----- design/led_strip_pattern_sequencer_unit.sv -----
// ----------------------------------------------------------------------------
// led_strip_pattern_sequencer_unit
// led strip animation: a ring of pixel cells stepped and streamed out
// ----------------------------------------------------------------------------
// streaming: a taken tick moves the FSM to ST_EMIT, then each emit registers the
//   pixel in cell 0 into the output register while the ring rotates one pixel per cycle
//   past cell 0, except while the output stalls; a tick is taken only in ST_IDLE
// reset: strip black, no mode applied, cylon moving forward, registers zero
// ----------------------------------------------------------------------------
module led_strip_pattern_sequencer_unit #(
  parameter int NUM_PIXELS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  lsps_in_if.sink     in_bus,
  lsps_out_if.source  out_bus,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int IDX_W = $clog2(NUM_PIXELS);

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_t;

  state_t                  state_r;
  logic [IDX_W-1:0]        cnt_r;
  logic                    out_valid_r;
  lsps_pkg::pix_idx_t      out_idx_r;
  lsps_pkg::rgb_t          out_rgb_r;
  logic                    out_last_r;

  lsps_pkg::mode_t         mode_r;
  lsps_pkg::rgb_t          color_r;
  lsps_pkg::mode_t         applied_mode_r;
  lsps_pkg::mode_t         applied_mode_nxt;
  logic                    bounce_r;
  logic                    bounce_nxt;

  lsps_pkg::rgb_t          pix   [NUM_PIXELS];
  lsps_pkg::rgb_t          fill_rgb;
  logic                    seed_en;
  logic [IDX_W-1:0]        seed_idx;
  lsps_pkg::cell_ctl_t     ctl;
  lsps_pkg::cell_op_t      step_op;

  logic                    tick_go;
  logic                    emit_go;
  logic                    entry;
  logic                    cfg_wr;

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= lsps_pkg::MODE_BLANK;
      color_r <= lsps_pkg::RGB_BLACK;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[2])
        lsps_pkg::REG_MODE:  mode_r  <= cfg_pwdata[lsps_pkg::MODE_W-1:0];
        lsps_pkg::REG_COLOR: color_r <= cfg_pwdata[lsps_pkg::RGB_W-1:0];
        default:             mode_r  <= mode_r;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      lsps_pkg::REG_MODE:  cfg_prdata = 32'(mode_r);
      lsps_pkg::REG_COLOR: cfg_prdata = 32'(color_r);
      default:             cfg_prdata = 32'd0;
    endcase
  end

  // handshakes
  assign in_bus.ready = (state_r == ST_IDLE);
  assign tick_go      = in_bus.valid & in_bus.ready;
  assign emit_go      = (state_r == ST_EMIT) & (~out_valid_r | out_bus.ready);

  // animation step decode
  assign entry = (applied_mode_r != mode_r);

  always_comb begin
    step_op          = lsps_pkg::CELL_HOLD;
    fill_rgb         = lsps_pkg::RGB_BLACK;
    seed_en          = 1'b0;
    seed_idx         = '0;
    applied_mode_nxt = mode_r;
    bounce_nxt       = bounce_r;
    unique case (mode_r)
      lsps_pkg::MODE_BLANK: begin
        if (entry) step_op = lsps_pkg::CELL_LOAD;
      end
      lsps_pkg::MODE_SOLID: begin
        if (entry) begin
          step_op  = lsps_pkg::CELL_LOAD;
          fill_rgb = color_r;
        end
      end
      lsps_pkg::MODE_RUN_FWD: begin
        if (entry) begin
          step_op = lsps_pkg::CELL_LOAD;
          seed_en = 1'b1;
        end else begin
          step_op = lsps_pkg::CELL_UP;
        end
      end
      lsps_pkg::MODE_RUN_REV: begin
        if (entry) begin
          step_op  = lsps_pkg::CELL_LOAD;
          seed_en  = 1'b1;
          seed_idx = IDX_W'(NUM_PIXELS - 1);
        end else begin
          step_op = lsps_pkg::CELL_DOWN;
        end
      end
      lsps_pkg::MODE_BOUNCE: begin
        if (entry) begin
          step_op    = lsps_pkg::CELL_LOAD;
          seed_en    = 1'b1;
          bounce_nxt = 1'b0;
        end else if (!bounce_r) begin
          if (pix[NUM_PIXELS-1] == color_r) bounce_nxt = 1'b1;
          else                              step_op    = lsps_pkg::CELL_UP;
        end else begin
          if (pix[0] == color_r) bounce_nxt = 1'b0;
          else                   step_op    = lsps_pkg::CELL_DOWN;
        end
      end
      default: begin
        applied_mode_nxt = applied_mode_r;
      end
    endcase
  end

  always_comb begin
    if (emit_go) begin
      ctl.op = lsps_pkg::CELL_DOWN;
    end else if (tick_go && in_bus.advance) begin
      ctl.op = step_op;
    end else begin
      ctl.op = lsps_pkg::CELL_HOLD;
    end
  end

  // ring of pixel cells
  for (genvar g = 0; g < NUM_PIXELS; g++) begin : g_cell
    lsps_pkg::rgb_t load_d;
    assign load_d = (seed_en && seed_idx == IDX_W'(g)) ? color_r : fill_rgb;

    lsps_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (ctl),
      .load_d  (load_d),
      .from_lo (pix[(g + NUM_PIXELS - 1) % NUM_PIXELS]),
      .from_hi (pix[(g + 1) % NUM_PIXELS]),
      .pix_q   (pix[g])
    );
  end

  // control and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      cnt_r          <= '0;
      out_valid_r    <= 1'b0;
      applied_mode_r <= lsps_pkg::MODE_NONE;
      bounce_r       <= 1'b0;
    end else begin
      if (emit_go) begin
        out_valid_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (tick_go) begin
            if (in_bus.advance) begin
              applied_mode_r <= applied_mode_nxt;
              bounce_r       <= bounce_nxt;
            end
            cnt_r   <= '0;
            state_r <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (emit_go) begin
            out_idx_r   <= lsps_pkg::PIX_W'(cnt_r);
            out_rgb_r   <= pix[0];
            out_last_r  <= (cnt_r == IDX_W'(NUM_PIXELS - 1));
            cnt_r       <= cnt_r + IDX_W'(1);
            if (cnt_r == IDX_W'(NUM_PIXELS - 1)) state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_bus.valid       = out_valid_r;
  assign out_bus.pixel_index = out_idx_r;
  assign out_bus.pixel_rgb   = out_rgb_r;
  assign out_bus.last_pixel  = out_last_r;

  // checks
  a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |-> (out_idx_r == lsps_pkg::PIX_W'(NUM_PIXELS - 1)))
    else $error("last pixel flag on wrong index");

  a_tick_emit: assert property (@(posedge clk) disable iff (!rst_n)
    tick_go |=> (state_r == ST_EMIT && cnt_r == '0))
    else $error("tick did not start streaming");

  a_applied: assert property (@(posedge clk) disable iff (!rst_n)
    (applied_mode_r <= lsps_pkg::MODE_BOUNCE) || (applied_mode_r == lsps_pkg::MODE_NONE))
    else $error("unused mode applied");

endmodule

// ----- design/lsps_cell.sv -----
// ----------------------------------------------------------------------------
// lsps_cell
// one pixel of the strip; loads, holds or takes a neighbor's pixel
// ----------------------------------------------------------------------------
module lsps_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  lsps_pkg::cell_ctl_t ctl,
  input  lsps_pkg::rgb_t      load_d,
  input  lsps_pkg::rgb_t      from_lo,
  input  lsps_pkg::rgb_t      from_hi,
  output lsps_pkg::rgb_t      pix_q
);

  lsps_pkg::rgb_t pix_r;
  lsps_pkg::rgb_t pix_nxt;

  always_comb begin
    unique case (ctl.op)
      lsps_pkg::CELL_HOLD: pix_nxt = pix_r;
      lsps_pkg::CELL_LOAD: pix_nxt = load_d;
      lsps_pkg::CELL_UP:   pix_nxt = from_lo;
      lsps_pkg::CELL_DOWN: pix_nxt = from_hi;
      default:             pix_nxt = pix_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pix_r <= lsps_pkg::RGB_BLACK;
    end else begin
      pix_r <= pix_nxt;
    end
  end

  assign pix_q = pix_r;

endmodule

// ----- tb/sv/tb_led_strip_pattern_sequencer_unit.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_led_strip_pattern_sequencer_unit
// Programs mode and colour over the register port and sends tick beats, both
// directed and random. Every mode, the unused mode codes and cylon bounces are
// covered. A scoreboard steps its own copy of the strip for each accepted
// tick that advances, then checks every pixel beat in order, with random
// idle cycles on both channels.
// ----------------------------------------------------------------------------
module tb_led_strip_pattern_sequencer_unit;

  localparam int STRIP_LEN   = 16;
  localparam int TICK_COUNT  = 450;
  localparam int CYCLE_LIMIT = 600000;

  typedef struct {
    lsps_pkg::pix_idx_t index;
    lsps_pkg::rgb_t     rgb;
    logic               last;
  } pixel_beat_t;

  class strip_scoreboard #(int LEN = 16);
    lsps_pkg::rgb_t  strip[LEN];
    lsps_pkg::mode_t applied_mode;
    logic            sweep_back;
    lsps_pkg::mode_t mode_reg;
    lsps_pkg::rgb_t  color_reg;
    pixel_beat_t     pending_pixels[$];
    int              errors;

    function new();
      foreach (strip[i]) strip[i] = lsps_pkg::RGB_BLACK;
      applied_mode = lsps_pkg::MODE_NONE;
      sweep_back   = 1'b0;
      mode_reg     = lsps_pkg::MODE_BLANK;
      color_reg    = lsps_pkg::RGB_BLACK;
      errors       = 0;
    endfunction

    task report(string msg);
      $display("ERROR at %0t: %s", $realtime, msg);
      errors++;
    endtask

    function void reg_written(logic sel, logic [31:0] data);
      if (sel == lsps_pkg::REG_MODE) mode_reg = data[lsps_pkg::MODE_W-1:0];
      else color_reg = data[lsps_pkg::RGB_W-1:0];
    endfunction

    function void fill_strip(lsps_pkg::rgb_t rgb);
      foreach (strip[i]) strip[i] = rgb;
    endfunction

    function void shift_up();
      lsps_pkg::rgb_t wrap;
      wrap = strip[LEN-1];
      for (int i = LEN - 1; i > 0; i--) strip[i] = strip[i-1];
      strip[0] = wrap;
    endfunction

    function void shift_down();
      lsps_pkg::rgb_t wrap;
      wrap = strip[0];
      for (int i = 0; i < LEN - 1; i++) strip[i] = strip[i+1];
      strip[LEN-1] = wrap;
    endfunction

    function void step_animation();
      logic entry;
      entry = (applied_mode != mode_reg);
      case (mode_reg)
        lsps_pkg::MODE_BLANK: begin
          if (entry) fill_strip(lsps_pkg::RGB_BLACK);
        end
        lsps_pkg::MODE_SOLID: begin
          if (entry) fill_strip(color_reg);
        end
        lsps_pkg::MODE_RUN_FWD: begin
          if (entry) begin
            fill_strip(lsps_pkg::RGB_BLACK);
            strip[0] = color_reg;
          end else begin
            shift_up();
          end
        end
        lsps_pkg::MODE_RUN_REV: begin
          if (entry) begin
            fill_strip(lsps_pkg::RGB_BLACK);
            strip[LEN-1] = color_reg;
          end else begin
            shift_down();
          end
        end
        lsps_pkg::MODE_BOUNCE: begin
          if (entry) begin
            fill_strip(lsps_pkg::RGB_BLACK);
            strip[0]   = color_reg;
            sweep_back = 1'b0;
          end else if (!sweep_back) begin
            if (strip[LEN-1] == color_reg) sweep_back = 1'b1;
            else shift_up();
          end else begin
            if (strip[0] == color_reg) sweep_back = 1'b0;
            else shift_down();
          end
        end
        default: return;
      endcase
      applied_mode = mode_reg;
    endfunction

    function void tick_taken(logic advance);
      pixel_beat_t beat;
      if (advance) step_animation();
      for (int i = 0; i < LEN; i++) begin
        beat.index = lsps_pkg::pix_idx_t'(i);
        beat.rgb   = strip[i];
        beat.last  = (i == LEN - 1);
        pending_pixels.push_back(beat);
      end
    endfunction

    function int pending_count();
      return pending_pixels.size();
    endfunction

    task pixel_seen(lsps_pkg::pix_idx_t index, lsps_pkg::rgb_t rgb, logic last);
      pixel_beat_t want;
      if (pending_pixels.size() == 0) begin
        report($sformatf("pixel beat index %0d with nothing pending", index));
      end else begin
        want = pending_pixels.pop_front();
        if (index !== want.index)
          report($sformatf("pixel_index %0d, expected %0d", index, want.index));
        if (rgb !== want.rgb)
          report($sformatf("pixel_rgb %06h at index %0d, expected %06h",
                           rgb, want.index, want.rgb));
        if (last !== want.last)
          report($sformatf("last_pixel %b at index %0d, expected %b",
                           last, want.index, want.last));
      end
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  lsps_in_if  in_bus();
  lsps_out_if out_bus();

  strip_scoreboard #(STRIP_LEN) sb;
  bit tx_steady;
  bit rx_steady;
  int ticks_sent;

  always #10 clk = ~clk;

  led_strip_pattern_sequencer_unit #(
    .NUM_PIXELS(STRIP_LEN)
  ) DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_bus      (in_bus),
    .out_bus     (out_bus),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  task send_tick(logic adv);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid   <= 1'b1;
    in_bus.advance <= adv;
    do @(posedge clk); while (in_bus.ready !== 1'b1);
    sb.tick_taken(adv);
    ticks_sent++;
  endtask

  task wait_idle();
    in_bus.valid <= 1'b0;
    while (sb.pending_count() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task write_reg(logic sel, logic [31:0] data);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {sel, 2'b00};
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (cfg_pready !== 1'b1);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    sb.reg_written(sel, data);
  endtask

  // pixel sink with random stalls
  initial begin : pixel_sink
    int stall;
    out_bus.ready <= 1'b0;
    @(posedge clk);
    forever begin
      stall = rx_steady ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        out_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk); while (out_bus.valid !== 1'b1);
      sb.pixel_seen(out_bus.pixel_index, out_bus.pixel_rgb, out_bus.last_pixel);
    end
  end

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : stimulus
    int          len;
    int          sel;
    logic [31:0] data;
    sb = new();
    tx_steady      = 1'b0;
    rx_steady      = 1'b0;
    ticks_sent     = 0;
    rst_n          <= 1'b0;
    in_bus.valid   <= 1'b0;
    in_bus.advance <= 1'b0;
    cfg_psel       <= 1'b0;
    cfg_penable    <= 1'b0;
    cfg_pwrite     <= 1'b0;
    cfg_paddr      <= '0;
    cfg_pwdata     <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // refresh with no mode applied, then off entry
    send_tick(1'b0);
    send_tick(1'b1);
    // solid white, then a colour write that must not refill
    wait_idle();
    write_reg(lsps_pkg::REG_COLOR, 32'hFFFF_FFFF);
    write_reg(lsps_pkg::REG_MODE, 32'(lsps_pkg::MODE_SOLID));
    send_tick(1'b1);
    send_tick(1'b1);
    wait_idle();
    write_reg(lsps_pkg::REG_COLOR, 32'h0012_3456);
    send_tick(1'b1);
    // run forward with junk in the upper register bits
    wait_idle();
    write_reg(lsps_pkg::REG_MODE, 32'hFFFF_FFF8 | 32'(lsps_pkg::MODE_RUN_FWD));
    write_reg(lsps_pkg::REG_COLOR, 32'hA500_FF00);
    send_tick(1'b1);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b1);
    wait_idle();
    write_reg(lsps_pkg::REG_MODE, 32'(lsps_pkg::MODE_RUN_REV));
    send_tick(1'b1);
    send_tick(1'b1);
    // cylon, then a colour change mid sweep
    wait_idle();
    write_reg(lsps_pkg::REG_COLOR, 32'h00FF_0000);
    write_reg(lsps_pkg::REG_MODE, 32'(lsps_pkg::MODE_BOUNCE));
    repeat (3) send_tick(1'b1);
    wait_idle();
    write_reg(lsps_pkg::REG_COLOR, 32'h0000_00FF);
    repeat (2) send_tick(1'b1);
    // unused mode codes leave the strip alone
    for (int m = lsps_pkg::MODE_BOUNCE + 1; m <= lsps_pkg::MODE_NONE; m++) begin
      wait_idle();
      write_reg(lsps_pkg::REG_MODE, 32'(m));
      send_tick(1'b1);
    end
    // black colour in cylon only flips direction
    wait_idle();
    write_reg(lsps_pkg::REG_COLOR, 32'(lsps_pkg::RGB_BLACK));
    write_reg(lsps_pkg::REG_MODE, 32'(lsps_pkg::MODE_BOUNCE));
    repeat (2) send_tick(1'b1);

    while (ticks_sent < TICK_COUNT) begin
      wait_idle();
      tx_steady = ($urandom_range(0, 3) == 0);
      rx_steady = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 3) != 0) begin
        data = $urandom();
        sel  = $urandom_range(0, 7);
        if (sel == 0) data[lsps_pkg::RGB_W-1:0] = lsps_pkg::RGB_BLACK;
        else if (sel == 1) data[lsps_pkg::RGB_W-1:0] = '1;
        write_reg(lsps_pkg::REG_COLOR, data);
      end
      if ($urandom_range(0, 3) != 0) begin
        data = $urandom();
        sel  = $urandom_range(0, 11);
        if (sel <= lsps_pkg::MODE_BOUNCE)
          data[lsps_pkg::MODE_W-1:0] = lsps_pkg::mode_t'(sel);
        else if (sel <= 9) data[lsps_pkg::MODE_W-1:0] = lsps_pkg::MODE_BOUNCE;
        else data[lsps_pkg::MODE_W-1:0] = lsps_pkg::mode_t'(
          $urandom_range(lsps_pkg::MODE_BOUNCE + 1, lsps_pkg::MODE_NONE));
        write_reg(lsps_pkg::REG_MODE, data);
      end
      len = $urandom_range(1, 48);
      repeat (len) begin
        send_tick($urandom_range(0, 9) != 0);
        if ($urandom_range(0, 59) == 0) wait_idle();
      end
    end

    wait_idle();
    repeat (20) @(posedge clk);
    if (sb.pending_count() != 0)
      sb.report($sformatf("%0d pixel beats never arrived", sb.pending_count()));
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
